/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the free list RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define DSFL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: %m");

// Expression must never be true outside reset.
`define DSFL_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition: %m");

`endif

/* hw/rtl/dsfl_pkg.sv */
// Shared constants, codes and control structs of the descriptor slot free list.
`timescale 1ns / 1ps

package dsfl_pkg;

    localparam int DSFL_POOL_DEPTH = 1024;

    localparam int ADDR_W     = 64;
    localparam int INC_W      = 16;
    localparam int SIZE_W     = 11;
    localparam int SLOT_W     = 10;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int DIV_W      = ADDR_W;

    localparam logic [INC_W-1:0] INC_RESET = INC_W'(32);

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_DISAGREE = 3'd2,
        ST_RANGE    = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CPU_BASE  = 2'd0,
        REG_GPU_BASE  = 2'd1,
        REG_INCREMENT = 2'd2,
        REG_POOL_SIZE = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } command_t;

    typedef struct packed {
        logic div_start;
        logic alloc_rd;
        logic alloc_mul;
        logic alloc_add;
        logic set_empty;
        logic free_check;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic stack_empty;
        logic div_done;
        logic out_free;
    } sts_t;

endpackage

/* hw/rtl/dsfl_ifs.sv */
// Request and response stream interfaces of the descriptor slot free list.
`timescale 1ns / 1ps

interface dsfl_req_if import dsfl_pkg::*; ();
    logic              valid;
    logic              ready;
    command_t          command;
    logic [ADDR_W-1:0] cpu_handle_in;
    logic [ADDR_W-1:0] gpu_handle_in;

    modport source (output valid, command, cpu_handle_in, gpu_handle_in, input ready);
    modport sink   (input valid, command, cpu_handle_in, gpu_handle_in, output ready);
endinterface

interface dsfl_rsp_if import dsfl_pkg::*; ();
    logic              valid;
    logic              ready;
    status_t           status;
    logic [SLOT_W-1:0] slot_index;
    logic [ADDR_W-1:0] cpu_handle_out;
    logic [ADDR_W-1:0] gpu_handle_out;

    modport source (output valid, status, slot_index, cpu_handle_out, gpu_handle_out,
                    input ready);
    modport sink   (input valid, status, slot_index, cpu_handle_out, gpu_handle_out,
                    output ready);
endinterface

/* hw/rtl/dsfl_divider.sv */
// Restoring divider, one quotient bit per cycle: 64-bit dividend by 16-bit divisor.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dsfl_divider import dsfl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [INC_W-1:0]  divisor,
    output logic              done,
    output logic [DIV_W-1:0]  quotient
);

    localparam int STEP_W = $clog2(DIV_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DIV_W-1:0]  dq_reg;
    logic [INC_W-1:0]  rem_reg;
    logic [INC_W-1:0]  dvs_reg;

    logic [INC_W:0]    rem_shift;
    logic [INC_W:0]    rem_diff;
    logic              fits;

    assign rem_shift = {rem_reg, dq_reg[DIV_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};
    assign fits      = (rem_shift >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dq_reg  <= {dq_reg[DIV_W-2:0], fits};
            rem_reg <= fits ? rem_diff[INC_W-1:0] : rem_shift[INC_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

    `DSFL_ASSERT_NEVER(a_div_restart_busy, clk, rst_n, start && busy_reg)
    `DSFL_ASSERT(a_div_done_pulse, clk, rst_n, done_reg |=> !done_reg && !busy_reg)

endmodule

/* hw/rtl/dsfl_datapath.sv */
// Free list datapath: registers, slot stack memory, index dividers, address math, output beat.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dsfl_datapath import dsfl_pkg::*;
#(
    parameter int POOL_DEPTH = DSFL_POOL_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [ADDR_W-1:0]     req_cpu_handle,
    input  logic [ADDR_W-1:0]     req_gpu_handle,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output status_t               rsp_status,
    output logic [SLOT_W-1:0]     rsp_slot_index,
    output logic [ADDR_W-1:0]     rsp_cpu_handle,
    output logic [ADDR_W-1:0]     rsp_gpu_handle
);

    localparam int IDX_W  = $clog2(POOL_DEPTH);
    localparam int CNT_W  = $clog2(POOL_DEPTH + 1);
    localparam int PROD_W = IDX_W + INC_W;

    // configuration
    logic [ADDR_W-1:0] cpu_base_reg;
    logic [ADDR_W-1:0] gpu_base_reg;
    logic [INC_W-1:0]  inc_reg;
    logic [CNT_W-1:0]  fill_size_reg;

    // stack control; entries below low_reg are not yet rewritten and read back as their refill value
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  low_reg;
    logic              out_valid_reg;

    logic [IDX_W-1:0]  stack_mem [POOL_DEPTH];
    logic [IDX_W-1:0]  rd_data_reg;
    logic              use_orig_reg;
    logic [PROD_W-1:0] prod_reg;

    status_t           res_status_reg;
    logic [SLOT_W-1:0] res_slot_reg;
    logic [ADDR_W-1:0] res_cpu_reg;
    logic [ADDR_W-1:0] res_gpu_reg;

    status_t           out_status_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic [ADDR_W-1:0] out_cpu_reg;
    logic [ADDR_W-1:0] out_gpu_reg;

    logic [SIZE_W-1:0] wr_size;
    logic [CNT_W-1:0]  wr_fill;
    logic [CNT_W-1:0]  top_cnt;
    logic [IDX_W-1:0]  top_idx;
    logic [IDX_W-1:0]  orig_val;
    logic [IDX_W-1:0]  slot_sel;
    logic              div_cpu_done;
    logic              div_gpu_done;
    logic [DIV_W-1:0]  q_cpu;
    logic [DIV_W-1:0]  q_gpu;
    logic              disagree;
    logic              out_of_range;
    logic              full;
    logic              push_en;

    assign wr_size  = cfg_data[SIZE_W-1:0];
    assign wr_fill  = (32'(wr_size) > 32'(POOL_DEPTH)) ? CNT_W'(POOL_DEPTH) : CNT_W'(wr_size);
    assign top_cnt  = count_reg - CNT_W'(1);
    assign top_idx  = top_cnt[IDX_W-1:0];
    assign orig_val = IDX_W'(fill_size_reg - count_reg);
    assign slot_sel = use_orig_reg ? orig_val : rd_data_reg;

    dsfl_divider u_div_cpu
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (req_cpu_handle - cpu_base_reg),
        .divisor  (inc_reg),
        .done     (div_cpu_done),
        .quotient (q_cpu)
    );

    dsfl_divider u_div_gpu
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (req_gpu_handle - gpu_base_reg),
        .divisor  (inc_reg),
        .done     (div_gpu_done),
        .quotient (q_gpu)
    );

    assign disagree     = (q_cpu != q_gpu);
    assign out_of_range = (q_cpu >= ADDR_W'(fill_size_reg));
    assign full         = (count_reg == CNT_W'(POOL_DEPTH));
    assign push_en      = cmd.free_check && !disagree && !out_of_range && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpu_base_reg  <= '0;
            gpu_base_reg  <= '0;
            inc_reg       <= INC_RESET;
            fill_size_reg <= CNT_W'(POOL_DEPTH);
            count_reg     <= CNT_W'(POOL_DEPTH);
            low_reg       <= CNT_W'(POOL_DEPTH);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.alloc_mul)
            begin
                count_reg <= top_cnt;
            end
            if (push_en)
            begin
                count_reg <= count_reg + CNT_W'(1);
                if (count_reg < low_reg)
                begin
                    low_reg <= count_reg;
                end
            end

            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_CPU_BASE:  cpu_base_reg <= cfg_data[ADDR_W-1:0];
                    REG_GPU_BASE:  gpu_base_reg <= cfg_data[ADDR_W-1:0];
                    REG_INCREMENT: inc_reg      <= cfg_data[INC_W-1:0];
                    REG_POOL_SIZE:
                    begin
                        fill_size_reg <= wr_fill;
                        count_reg     <= wr_fill;
                        low_reg       <= wr_fill;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            stack_mem[count_reg[IDX_W-1:0]] <= q_cpu[IDX_W-1:0];
        end
        if (cmd.alloc_rd)
        begin
            rd_data_reg <= stack_mem[top_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.alloc_rd)
        begin
            use_orig_reg <= (count_reg <= low_reg);
        end
        if (cmd.alloc_mul)
        begin
            prod_reg     <= PROD_W'(slot_sel) * PROD_W'(inc_reg);
            res_slot_reg <= SLOT_W'(slot_sel);
        end
        if (cmd.alloc_add)
        begin
            res_status_reg <= ST_OK;
            res_cpu_reg    <= cpu_base_reg + ADDR_W'(prod_reg);
            res_gpu_reg    <= gpu_base_reg + ADDR_W'(prod_reg);
        end
        if (cmd.set_empty)
        begin
            res_status_reg <= ST_EMPTY;
            res_slot_reg   <= '0;
            res_cpu_reg    <= '0;
            res_gpu_reg    <= '0;
        end
        if (cmd.free_check)
        begin
            res_cpu_reg <= '0;
            res_gpu_reg <= '0;
            if (disagree)
            begin
                res_status_reg <= ST_DISAGREE;
                res_slot_reg   <= '0;
            end
            else if (out_of_range)
            begin
                res_status_reg <= ST_RANGE;
                res_slot_reg   <= '0;
            end
            else if (full)
            begin
                res_status_reg <= ST_FULL;
                res_slot_reg   <= '0;
            end
            else
            begin
                res_status_reg <= ST_OK;
                res_slot_reg   <= SLOT_W'(q_cpu);
            end
        end
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_cpu_reg    <= res_cpu_reg;
            out_gpu_reg    <= res_gpu_reg;
        end
    end

    assign sts.stack_empty = (count_reg == '0);
    assign sts.div_done    = div_cpu_done && div_gpu_done;
    assign sts.out_free    = !out_valid_reg || rsp_ready;

    assign rsp_valid      = out_valid_reg;
    assign rsp_status     = out_status_reg;
    assign rsp_slot_index = out_slot_reg;
    assign rsp_cpu_handle = out_cpu_reg;
    assign rsp_gpu_handle = out_gpu_reg;

    `DSFL_ASSERT(a_no_beat_overwrite, clk, rst_n, cmd.load_out |-> !out_valid_reg || rsp_ready)
    `DSFL_ASSERT(a_stack_marks, clk, rst_n,
                 low_reg <= fill_size_reg && count_reg <= CNT_W'(POOL_DEPTH))

endmodule

/* hw/rtl/dsfl_ctrl.sv */
// Free list controller: sequences allocate and free operations over the datapath.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dsfl_ctrl import dsfl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  command_t in_command,
    output logic     in_ready,
    input  sts_t     sts,
    output cmd_t     cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC_RD,
        S_ALLOC_MUL,
        S_ALLOC_ADD,
        S_FREE_WAIT,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_command == CMD_FREE)
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_FREE_WAIT;
                    end
                    else
                    begin
                        state_next = S_ALLOC_RD;
                    end
                end
            end
            S_ALLOC_RD:
            begin
                if (sts.stack_empty)
                begin
                    cmd.set_empty = 1'b1;
                    state_next    = S_FINISH;
                end
                else
                begin
                    cmd.alloc_rd = 1'b1;
                    state_next   = S_ALLOC_MUL;
                end
            end
            S_ALLOC_MUL:
            begin
                cmd.alloc_mul = 1'b1;
                state_next    = S_ALLOC_ADD;
            end
            S_ALLOC_ADD:
            begin
                cmd.alloc_add = 1'b1;
                state_next    = S_FINISH;
            end
            S_FREE_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.free_check = 1'b1;
                    state_next     = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `DSFL_ASSERT(a_div_done_in_wait, clk, rst_n, sts.div_done |-> state_reg == S_FREE_WAIT)

endmodule

/* hw/rtl/descriptor_slot_free_list.sv */
// Top level of the descriptor slot free list: LIFO slot allocator over two address spaces.
//
//   channel  dir  handshake         payload
//   req      in   valid/ready       command, cpu_handle_in, gpu_handle_in
//   rsp      out  valid/ready       status, slot_index, cpu_handle_out, gpu_handle_out
//   cfg      in   cfg_we            cfg_index, cfg_data
//
// Allocate: stack read, stride multiply, base add, output load.
// An allocate on an empty stack does an empty check, then an output load.
// Free: both handles go through the bit-serial 64-bit index dividers, then the check and output load.
// One beat in flight; the next is taken while a result waits in the output register.
// Reset needs no clearing pass: a low-water mark marks stack entries not yet rewritten.
`timescale 1ns / 1ps

module descriptor_slot_free_list import dsfl_pkg::*;
#(
    parameter int POOL_DEPTH = DSFL_POOL_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    dsfl_req_if.sink              req,
    dsfl_rsp_if.source            rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    dsfl_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req.valid),
        .in_command (req.command),
        .in_ready   (req.ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    dsfl_datapath #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .req_cpu_handle (req.cpu_handle_in),
        .req_gpu_handle (req.gpu_handle_in),
        .rsp_valid      (rsp.valid),
        .rsp_ready      (rsp.ready),
        .rsp_status     (rsp.status),
        .rsp_slot_index (rsp.slot_index),
        .rsp_cpu_handle (rsp.cpu_handle_out),
        .rsp_gpu_handle (rsp.gpu_handle_out)
    );

endmodule
